FILE: rtl/mavg_pkg.sv
// shared constants, types and sequencer states for the moving average filter
// no dependencies; imported by mavg_div and moving_average_minmax_filter
package mavg_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W       = SAMPLE_BITS + ADDR_W + 1;
  localparam int MAG_W       = SUM_W - 1;
  localparam int DSTEP_W     = $clog2(MAG_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OLD,
    S_DSTART,
    S_SCAN,
    S_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                   busy;
    logic [SAMPLE_BITS-1:0] quot;
  } div_res_t;

endpackage

FILE: rtl/mavg_div.sv
// serial restoring divider: signed running sum over unsigned fill count
// one quotient bit per cycle, truncates toward zero; uses mavg_pkg
module mavg_div
  import mavg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output div_res_t                res
);

  logic               busy_r, busy_nxt;
  logic               neg_r, neg_nxt;
  logic [MAG_W-1:0]   dvd_r, dvd_nxt;
  logic [CNT_W:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]   dsr_r, dsr_nxt;
  logic [DSTEP_W-1:0] step_r, step_nxt;
  logic [CNT_W:0]     trial;
  logic               qbit;
  logic [SUM_W-1:0]   mag_full;
  logic [SAMPLE_BITS-1:0] qlow;

  assign mag_full = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial    = {rem_r[CNT_W-1:0], dvd_r[MAG_W-1]};
  assign qbit     = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[SUM_W-1];
      dvd_nxt  = mag_full[MAG_W-1:0];
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      step_nxt = DSTEP_W'(MAG_W);
    end else if (busy_r) begin
      rem_nxt  = qbit ? (trial - {1'b0, dsr_r}) : trial;
      dvd_nxt  = {dvd_r[MAG_W-2:0], qbit};
      step_nxt = step_r - 1'b1;
      if (step_r == DSTEP_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    neg_r <= neg_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  // low bits of the negated quotient equal the negation of its low bits
  assign qlow     = dvd_r[SAMPLE_BITS-1:0];
  assign res.busy = busy_r;
  assign res.quot = neg_r ? (~qlow + 1'b1) : qlow;

`ifndef NO_ASSERTIONS
  a_step_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> step_r == '0 || $past(busy_r))
    else $error("divider step count left over while idle");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(start) |-> rem_r < {1'b0, dsr_r})
    else $error("partial remainder not below divisor");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider not busy after start");
`endif

endmodule

FILE: rtl/moving_average_minmax_filter.sv
// sliding-window average with min/max/midpoint of absolute sample values
// top level: ring store, running sum, scan sequencer; uses mavg_pkg, mavg_div
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid in_ready in_mode in_sample          | item in
//  out     | out_valid out_ready out_average out_max_abs  | item out
//          | out_min_abs out_mid_abs                      |
//  cfg     | cfg_valid cfg_ready cfg_window_size          | register write
//
// a sample item writes the store and the running sum, starts the divider and
// scans the fill: the scan reads one store entry per cycle through a single read
// port while the serial divider runs alongside it. a clear item goes straight
// to the finish state; in_ready returns in the same cycle that out_valid rises.
// reset gives window size 64 and an empty filter; store contents are tracked
// by the fill count, so no clearing pass. in_ready stays low while an item is
// in work; a held result does not block the next accept.
module moving_average_minmax_filter
  import mavg_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic [SAMPLE_BITS-1:0]        out_max_abs,
  output logic [SAMPLE_BITS-1:0]        out_min_abs,
  output logic [SAMPLE_BITS-1:0]        out_mid_abs,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CNT_W-1:0]              cfg_window_size
);

  state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      rd_addr;

  logic [CNT_W-1:0]       win_r, count_r, idx_r;
  logic [ADDR_W-1:0]      ptr_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   clr_r, rd_pend_r;
  logic [SAMPLE_BITS-1:0] hi_r, lo_r;
  logic                   out_valid_r;
  logic signed [SAMPLE_BITS-1:0] avg_out_r;
  logic [SAMPLE_BITS-1:0] max_out_r, min_out_r, mid_out_r;

  logic                   in_acc, cfg_acc, out_take, load_out;
  logic                   div_start;
  div_res_t               div_res;
  logic [CNT_W-1:0]       win_sat;
  logic [SAMPLE_BITS-1:0] old_val, rd_mag;
  logic [CNT_W-1:0]       ptr_inc;
  logic [SAMPLE_BITS:0]   mid_sum;

  assign in_acc   = in_valid && in_ready;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_take = out_valid_r && out_ready;
  assign load_out = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    win_sat = cfg_window_size;
    if (cfg_window_size == '0) begin
      win_sat = CNT_W'(1);
    end else if (cfg_window_size > CNT_W'(MAX_WINDOW)) begin
      win_sat = CNT_W'(MAX_WINDOW);
    end
  end

  // entries at or above the fill count are not valid, so they are taken as zero
  assign old_val = ({1'b0, ptr_r} < count_r) ? rd_data_r : '0;
  assign ptr_inc = {1'b0, ptr_r} + 1'b1;
  assign rd_mag  = rd_data_r[SAMPLE_BITS-1] ? (~rd_data_r + 1'b1) : rd_data_r;
  assign mid_sum = {1'b0, hi_r} + {1'b0, lo_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_mode ? S_FINISH : S_OLD;
        end
      end
      S_OLD:    state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_SCAN;
      S_SCAN: begin
        if (!rd_pend_r && idx_r >= count_r) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!div_res.busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    rd_addr   = ptr_r;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        mem_re    = 1'b1;
      end
      S_OLD: mem_we = 1'b1;
      S_DSTART: begin
        div_start = 1'b1;
        mem_re    = 1'b1;
        rd_addr   = '0;
      end
      S_SCAN: begin
        mem_re  = idx_r < count_r;
        rd_addr = idx_r[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr_r] <= sample_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= CNT_W'(MAX_WINDOW);
      count_r     <= '0;
      ptr_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      clr_r       <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        win_r   <= win_sat;
        count_r <= '0;
        ptr_r   <= '0;
        sum_r   <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            clr_r <= in_mode;
            if (in_mode) begin
              count_r <= '0;
              ptr_r   <= '0;
              sum_r   <= '0;
            end
          end
        end
        S_OLD: begin
          sum_r <= sum_r + SUM_W'(signed'(sample_r)) - SUM_W'(signed'(old_val));
          ptr_r <= (ptr_inc >= win_r) ? '0 : ptr_inc[ADDR_W-1:0];
          if (count_r < win_r) begin
            count_r <= count_r + 1'b1;
          end
        end
        S_DSTART: begin
          idx_r     <= CNT_W'(1);
          rd_pend_r <= 1'b1;
        end
        S_SCAN: begin
          rd_pend_r <= idx_r < count_r;
          if (idx_r < count_r) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: ;
      endcase
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
    end
    if (state_r == S_DSTART) begin
      hi_r <= '0;
      lo_r <= '1;
    end else if (state_r == S_SCAN && rd_pend_r) begin
      if (rd_mag > hi_r) begin
        hi_r <= rd_mag;
      end
      if (rd_mag < lo_r) begin
        lo_r <= rd_mag;
      end
    end
    if (load_out) begin
      if (clr_r) begin
        avg_out_r <= '0;
        max_out_r <= '0;
        min_out_r <= '0;
        mid_out_r <= '0;
      end else begin
        avg_out_r <= div_res.quot;
        max_out_r <= hi_r;
        min_out_r <= lo_r;
        mid_out_r <= mid_sum[SAMPLE_BITS:1];
      end
    end
  end

  mavg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .res      (div_res)
  );

  assign out_valid   = out_valid_r;
  assign out_average = avg_out_r;
  assign out_max_abs = max_out_r;
  assign out_min_abs = min_out_r;
  assign out_mid_abs = mid_out_r;

`ifndef NO_ASSERTIONS
  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= win_r)
    else $error("fill count above window size");
  a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ptr_r} < win_r)
    else $error("write pointer outside window");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input ready right after an accepted item");
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH)
    else $error("result raised outside finish state");
  a_div_done_before_out: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && !clr_r |-> !div_res.busy)
    else $error("result loaded while divider busy");
`endif

endmodule
